>>> rtl/bvp_pkg.sv
// shared constants and widths for the battery voltage to percent block
`default_nettype none

package bvp_pkg;

    localparam int MAX_POINTS = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    localparam int MV_W  = 16;
    localparam int PCT_W = 8;
    localparam int ENT_W = MV_W + PCT_W;

    // serial divider widths: |dv * dp| < 2^24, |den| < 2^16
    localparam int NUM_W  = 24;
    localparam int DEN_W  = 16;
    localparam int DCNT_W = $clog2(NUM_W + 1);

    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] MODE_CLEAR   = 2'd0;
    localparam logic [1:0] MODE_APPEND  = 2'd1;
    localparam logic [1:0] MODE_CONVERT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_MV = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_MV  = 2'd1;

    localparam logic [MV_W-1:0] EMPTY_MV_RST = 16'd3300;
    localparam logic [MV_W-1:0] FULL_MV_RST  = 16'd4200;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quot;
    } t_div_rsp;

endpackage

`default_nettype wire

>>> rtl/bvp_in_if.sv
// input channel: command beats (clear, append, convert)
`default_nettype none

interface bvp_in_if
    import bvp_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [1:0]              mode;
    logic [MV_W-1:0]         voltage_mv;
    logic signed [PCT_W-1:0] point_percent;

    modport source (output valid, output mode, output voltage_mv, output point_percent,
                    input ready);
    modport sink   (input valid, input mode, input voltage_mv, input point_percent,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/bvp_out_if.sv
// output channel: conversion result beats
`default_nettype none

interface bvp_out_if
    import bvp_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [PCT_W-1:0] percent;
    logic                    used_table;

    modport source (output valid, output percent, output used_table, input ready);
    modport sink   (input valid, input percent, input used_table, output ready);
endinterface

`default_nettype wire

>>> rtl/bvp_ram.sv
// generic single write port ram with registered read
`default_nettype none

module bvp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/bvp_div.sv
// restoring unsigned divider, one quotient bit per cycle
`default_nettype none

module bvp_div
    import bvp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic [DEN_W-1:0]  r_rem, n_rem;
    logic [NUM_W-1:0]  r_quo, n_quo;
    logic [DEN_W-1:0]  r_den, n_den;
    logic [DCNT_W-1:0] r_cnt, n_cnt;
    logic              r_done, n_done;
    logic [DEN_W:0]    w_shift;
    logic [DEN_W:0]    w_diff;

    always_comb begin
        w_shift = {r_rem, r_quo[NUM_W-1]};
        w_diff  = w_shift - {1'b0, r_den};
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_den   = r_den;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        if (i_req.start) begin
            n_rem = '0;
            n_quo = i_req.num;
            n_den = i_req.den;
            n_cnt = DCNT_W'(NUM_W);
        end else if (r_cnt != '0) begin
            // trial subtract, keep it when it does not go negative
            if (w_shift >= {1'b0, r_den}) begin
                n_rem = w_diff[DEN_W-1:0];
                n_quo = {r_quo[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = w_shift[DEN_W-1:0];
                n_quo = {r_quo[NUM_W-2:0], 1'b0};
            end
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == DCNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

`default_nettype wire

>>> rtl/battery_voltage_to_percent.sv
// top level: calibration table, segment search sequencer and shared mul/div datapath
//
// usage
//  - in_ch carries command beats: clear the table, append a (millivolt, percent)
//    point, or convert a millivolt sample; clear and append give no result beat
//  - out_ch carries one result beat (percent, used_table) per convert beat
//  - i_cfg_we/i_cfg_idx/i_cfg_data write empty_mv (index 0) and full_mv (index 1);
//    other indexes are ignored; write only while no convert is in flight
//  - clear and append leave the sequencer idle; in_ch stays ready for the next beat
//  - a convert with a table runs on one sequencer: table end point reads (S_FIRST,
//    S_LAST), a walk over the stored points one per cycle (S_SCAN), a multiply step
//    (S_MUL), a divider load step (S_DIVGO) and a serial divide in S_DIV, which
//    then takes the quotient; end point hits skip the rest
//  - the degenerate range registers its result in the accepting cycle; the linear
//    fallback skips the end point reads and the walk and goes straight to the multiply
//  - in_ch is not ready while a convert runs or while an undelivered result
//    sits in the output register; a stalled receiver therefore holds off in_ch
//  - reset empties the table and loads empty_mv 3300, full_mv 4200
//  - the point memory itself is not cleared; only entries below the count are read
`default_nettype none

module battery_voltage_to_percent
    import bvp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [MV_W-1:0]      i_cfg_data,
    bvp_in_if.sink                    in_ch,
    bvp_out_if.source                 out_ch
);

    localparam int SUM_W  = NUM_W + 2;   // base plus signed quotient
    localparam int DV_W   = MV_W + 1;    // signed voltage difference
    localparam int DP_W   = PCT_W + 1;   // signed percent difference
    localparam int PROD_W = DV_W + DP_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_LAST,
        S_SCAN,
        S_MUL,
        S_DIVGO,
        S_DIV
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [MV_W-1:0] r_empty_mv, r_full_mv;

    // table control
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] w_last;

    // working registers of one convert
    logic [MV_W-1:0]          r_v, n_v;
    logic [MV_W-1:0]          r_prev_v, n_prev_v;
    logic signed [PCT_W-1:0]  r_prev_p, n_prev_p;
    logic signed [DV_W-1:0]   r_dv, n_dv;
    logic signed [DP_W-1:0]   r_dp, n_dp;
    logic signed [DV_W-1:0]   r_den, n_den;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic signed [PCT_W-1:0]  r_base, n_base;
    logic                     r_neg, n_neg;

    // output register
    logic                    r_out_vld, n_out_vld;
    logic signed [PCT_W-1:0] r_out_pct, n_out_pct;
    logic                    r_out_tab, n_out_tab;

    // memory and divider hookup
    logic                    w_we;
    logic [IDX_W-1:0]        w_raddr;
    logic [ENT_W-1:0]        w_rdata;
    logic [MV_W-1:0]         w_cur_v;
    logic signed [PCT_W-1:0] w_cur_p;
    t_div_req                w_div_req;
    t_div_rsp                w_div_rsp;

    logic                     w_in_acc;
    logic                     w_bracket;
    logic signed [PROD_W-1:0] w_abs_prod;
    logic signed [DV_W-1:0]   w_abs_den;
    logic signed [SUM_W-1:0]  w_q;
    logic signed [SUM_W-1:0]  w_sum;

    function automatic logic signed [PCT_W-1:0] clamp_pct(input logic signed [SUM_W-1:0] p);
        logic signed [PCT_W-1:0] res;
        if (p < 0) begin
            res = '0;
        end else if (p > SUM_W'(100)) begin
            res = PCT_W'(100);
        end else begin
            res = p[PCT_W-1:0];
        end
        return res;
    endfunction

    assign in_ch.ready = (r_state == S_IDLE) && (!r_out_vld || out_ch.ready);
    assign w_in_acc    = in_ch.valid && in_ch.ready;

    assign out_ch.valid      = r_out_vld;
    assign out_ch.percent    = r_out_pct;
    assign out_ch.used_table = r_out_tab;

    assign w_last  = IDX_W'(r_count - 1'b1);
    assign w_cur_v = w_rdata[ENT_W-1:PCT_W];
    assign w_cur_p = w_rdata[PCT_W-1:0];

    // append lands at the current fill position
    assign w_we = w_in_acc && (in_ch.mode == MODE_APPEND) && (in_ch.voltage_mv != '0)
                  && (r_count < CNT_W'(MAX_POINTS));

    bvp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_POINTS)
    ) u_points (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata ({in_ch.voltage_mv, in_ch.point_percent}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // sample lies between previous and current point, either order
    assign w_bracket = ((r_v <= r_prev_v) && (r_v >= w_cur_v))
                    || ((r_v >= r_prev_v) && (r_v <= w_cur_v));

    assign w_abs_prod = r_prod[PROD_W-1] ? -r_prod : r_prod;
    assign w_abs_den  = r_den[DV_W-1] ? -r_den : r_den;

    assign w_div_req.start = (r_state == S_DIVGO);
    assign w_div_req.num   = w_abs_prod[NUM_W-1:0];
    assign w_div_req.den   = w_abs_den[DEN_W-1:0];

    bvp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // truncating quotient gets the sign back, then the segment base is added
    assign w_q   = r_neg ? -SUM_W'({1'b0, w_div_rsp.quot}) : SUM_W'({1'b0, w_div_rsp.quot});
    assign w_sum = SUM_W'(r_base) + w_q;

    // read address: end points first, then a walk over the segments
    always_comb begin
        unique case (r_state)
            S_FIRST: w_raddr = w_last;
            S_LAST:  w_raddr = IDX_W'(1);
            S_SCAN:  w_raddr = r_idx + 1'b1;
            default: w_raddr = '0;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_v       = r_v;
        n_prev_v  = r_prev_v;
        n_prev_p  = r_prev_p;
        n_dv      = r_dv;
        n_dp      = r_dp;
        n_den     = r_den;
        n_prod    = r_prod;
        n_base    = r_base;
        n_neg     = r_neg;
        n_out_vld = r_out_vld;
        n_out_pct = r_out_pct;
        n_out_tab = r_out_tab;

        if (out_ch.valid && out_ch.ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    unique case (in_ch.mode)
                        MODE_CLEAR: n_count = '0;
                        MODE_APPEND: begin
                            if (w_we) begin
                                n_count = r_count + 1'b1;
                            end
                        end
                        MODE_CONVERT: begin
                            n_v       = in_ch.voltage_mv;
                            n_out_tab = (r_count >= CNT_W'(2));
                            if (r_count >= CNT_W'(2)) begin
                                n_state = S_FIRST;
                            end else if (r_full_mv <= r_empty_mv) begin
                                // degenerate fallback range
                                n_out_pct = '0;
                                n_out_vld = 1'b1;
                            end else begin
                                // linear fallback: (v - empty) * 100 / (full - empty)
                                n_dv    = DV_W'(in_ch.voltage_mv) - DV_W'(r_empty_mv);
                                n_dp    = DP_W'(100);
                                n_den   = DV_W'(r_full_mv) - DV_W'(r_empty_mv);
                                n_base  = '0;
                                n_state = S_MUL;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_FIRST: begin
                n_prev_v = w_cur_v;
                n_prev_p = w_cur_p;
                if (r_v >= w_cur_v) begin
                    n_out_pct = clamp_pct(SUM_W'(w_cur_p));
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                if (r_v <= w_cur_v) begin
                    n_out_pct = clamp_pct(SUM_W'(w_cur_p));
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    n_idx   = IDX_W'(1);
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_bracket) begin
                    if (r_prev_v == w_cur_v) begin
                        // flat segment gives its first percent as is
                        n_out_pct = r_prev_p;
                        n_out_vld = 1'b1;
                        n_state   = S_IDLE;
                    end else begin
                        n_dv    = DV_W'(r_v) - DV_W'(w_cur_v);
                        n_dp    = DP_W'(r_prev_p) - DP_W'(w_cur_p);
                        n_den   = DV_W'(r_prev_v) - DV_W'(w_cur_v);
                        n_base  = w_cur_p;
                        n_state = S_MUL;
                    end
                end else if (r_idx == w_last) begin
                    // no segment brackets the sample
                    n_out_pct = PCT_W'(50);
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    n_prev_v = w_cur_v;
                    n_prev_p = w_cur_p;
                    n_idx    = r_idx + 1'b1;
                end
            end
            S_MUL: begin
                n_prod  = r_dv * r_dp;
                n_state = S_DIVGO;
            end
            S_DIVGO: begin
                n_neg   = r_prod[PROD_W-1] ^ r_den[DV_W-1];
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    n_out_pct = clamp_pct(w_sum);
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_out_vld  <= 1'b0;
            r_empty_mv <= EMPTY_MV_RST;
            r_full_mv  <= FULL_MV_RST;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
            if (i_cfg_we && (i_cfg_idx == REG_EMPTY_MV)) begin
                r_empty_mv <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_idx == REG_FULL_MV)) begin
                r_full_mv <= i_cfg_data;
            end
        end
        r_idx     <= n_idx;
        r_v       <= n_v;
        r_prev_v  <= n_prev_v;
        r_prev_p  <= n_prev_p;
        r_dv      <= n_dv;
        r_dp      <= n_dp;
        r_den     <= n_den;
        r_prod    <= n_prod;
        r_base    <= n_base;
        r_neg     <= n_neg;
        r_out_pct <= n_out_pct;
        r_out_tab <= n_out_tab;
    end

endmodule

`default_nettype wire
